>>> hw/rtl/assert_macros.svh
// assertion macros shared by the phaser checker
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle while reset is held
`define SAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also runs during reset
`define SAP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/sap_pkg.sv
// shared types and constants of the stereo all-pass phaser
// no dependencies
package sap_pkg;

    localparam int DATA_W       = 32;
    localparam int SAMPLE_W     = 16;
    localparam int PERIOD_BITS  = 24;
    localparam int MAX_SECTIONS = 6;
    localparam int SEC_W        = 3;
    localparam int FB_W         = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CH_WORDS     = 4 * MAX_SECTIONS;
    localparam int HIST_DEPTH   = 2 * CH_WORDS;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int MUL_B_W      = DATA_W + 1;
    localparam int MUL_P_W      = DATA_W + MUL_B_W + 1;
    localparam int MUL_CNT_W    = $clog2(MUL_B_W);

    localparam logic signed [DATA_W-1:0] CLAMP_HI = 32'sh0100_0000;
    localparam logic signed [DATA_W-1:0] CLAMP_LO = -32'sh0100_0000;

    localparam logic [SEC_W-1:0]       RST_BIQUAD = 3'd3;
    localparam logic [DATA_W-1:0]      RST_WET    = 32'd2147483648;
    localparam logic [FB_W-1:0]        RST_FB     = 17'd28180;
    localparam logic [DATA_W-1:0]      RST_LOW    = 32'd1543656344;
    localparam logic [DATA_W-1:0]      RST_HIGH   = 32'd2066648069;
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD = 24'd315000;
    localparam logic [PERIOD_BITS-1:0] RST_POS_R  = RST_PERIOD >> 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIQUAD = 3'd0,
        REG_WET    = 3'd1,
        REG_FB     = 3'd2,
        REG_LOW    = 3'd3,
        REG_HIGH   = 3'd4,
        REG_PERIOD = 3'd5
    } cfg_reg_t;

endpackage

>>> hw/rtl/sap_if.sv
// request channel interfaces of the phaser: sample pairs in, mixed pairs out
// depends on sap_pkg
interface sap_in_if import sap_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic signed [DATA_W-1:0]   mix_left;
    logic signed [DATA_W-1:0]   mix_right;

    modport source (output valid, in_left, in_right, mix_left, mix_right, input ready);
    modport sink   (input valid, in_left, in_right, mix_left, mix_right, output ready);
endinterface

interface sap_out_if import sap_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_left;
    logic signed [DATA_W-1:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink   (input valid, out_left, out_right, output ready);
endinterface

>>> hw/rtl/stereo_allpass_phaser.sv
// stereo all-pass phaser: sequencer, lfo, history store and shared serial multiplier
// depends on sap_pkg, sap_if, sap_ram and sap_serial_mul
//
// usage:
//   din carries one request per stereo pair (in_left, in_right, mix_left, mix_right);
//   dout returns one request per input with out_left and out_right.
//   configuration is written through cfg_write, cfg_index and cfg_data while idle;
//   writing the sweep limits or the period restarts both lfos.
// timing:
//   one pair is worked at a time. per channel the work runs over its n sections,
//   plus a serial division when that channel's lfo turns. the cost of an item is
//   set by the single bit-serial multiplier, two products per section.
//   din.ready is high only while no pair is being worked.
// reset:
//   configuration registers take their default values, both lfos restart and the section history
//   reads as zero until written.
// stalls:
//   a finished result waits in the output register; a new pair is taken meanwhile,
//   and its result waits at the end of its work until the register is free.
module stereo_allpass_phaser import sap_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    sap_in_if.sink               din,
    sap_out_if.source            dout
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_LFO_CHK  = 12'b0000_0000_0010,
        ST_DIV      = 12'b0000_0000_0100,
        ST_FB_RD    = 12'b0000_0000_1000,
        ST_FB_CLAMP = 12'b0000_0001_0000,
        ST_FB_MUL   = 12'b0000_0010_0000,
        ST_SEC_RD   = 12'b0000_0100_0000,
        ST_MUL1     = 12'b0000_1000_0000,
        ST_MUL2     = 12'b0001_0000_0000,
        ST_SEC_WR   = 12'b0010_0000_0000,
        ST_WET      = 12'b0100_0000_0000,
        ST_FIN      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SEC_W-1:0]       biquad_reg, biquad_next;
    logic [DATA_W-1:0]      wet_reg, wet_next;
    logic [FB_W-1:0]        fb_reg, fb_next;
    logic [DATA_W-1:0]      low_reg, low_next;
    logic [DATA_W-1:0]      high_reg, high_next;
    logic [PERIOD_BITS-1:0] period_reg, period_next;

    // lfo per channel
    logic [PERIOD_BITS-1:0] pos_reg [2];
    logic [PERIOD_BITS-1:0] pos_next [2];
    logic [DATA_W-1:0]      coef_reg [2];
    logic [DATA_W-1:0]      coef_next [2];
    logic [DATA_W-1:0]      step_reg [2];
    logic [DATA_W-1:0]      step_next [2];

    // work registers
    logic                   ch_reg, ch_next;
    logic [SEC_W-1:0]       k_reg, k_next;
    logic [2:0]             j_reg, j_next;
    logic [SEC_W-1:0]       n_reg, n_next;
    logic [DATA_W-1:0]      xin_reg, xin_next;
    logic [DATA_W-1:0]      mixl_reg, mixl_next;
    logic [DATA_W-1:0]      mixr_reg, mixr_next;
    logic [DATA_W-1:0]      x0_reg, x0_next;
    logic [DATA_W-1:0]      tmp_reg, tmp_next;
    logic [DATA_W-1:0]      s_reg [4];
    logic [DATA_W-1:0]      s_next [4];
    logic [DATA_W-1:0]      resl_reg, resl_next;
    logic [DATA_W-1:0]      resr_reg, resr_next;
    logic [PERIOD_BITS-1:0] posw_reg, posw_next;
    logic                   neg_reg, neg_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0]      quo_reg, quo_next;
    logic [PERIOD_BITS-1:0] left_reg, left_next;
    logic [4:0]             dcnt_reg, dcnt_next;

    // history valid bits and output register
    logic [HIST_DEPTH-1:0] hv_reg, hv_next;
    logic                  rvalid_reg, rvalid_next;
    logic                  ovalid_reg, ovalid_next;
    logic [DATA_W-1:0]     outl_reg, outl_next;
    logic [DATA_W-1:0]     outr_reg, outr_next;

    // memory and multiplier hookup
    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [HIST_AW-1:0]  ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                mul_start;
    logic [DATA_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [MUL_P_W-1:0]  mul_prod;

    sap_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sap_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        logic [PERIOD_BITS-1:0] eff;
        logic [PERIOD_BITS-1:0] half;
        logic [PERIOD_BITS-1:0] pos_e;
        logic [PERIOD_BITS-1:0] pos_inc;
        logic [PERIOD_BITS:0]   div_r;
        logic                   div_ge;
        logic [DATA_W-1:0]      quo_fin;
        logic [DATA_W-1:0]      target;
        logic [DATA_W-1:0]      coef_c;
        logic [DATA_W-1:0]      hval;
        logic [DATA_W-1:0]      last;
        logic [DATA_W-1:0]      wraw;
        logic [DATA_W-1:0]      wet;
        logic [DATA_W-1:0]      tval;
        logic [HIST_AW-1:0]     base;
        logic [HIST_AW-1:0]     sec_addr;
        logic [HIST_AW-1:0]     last_addr;
        logic signed [SAMPLE_W:0] psum;
        logic [PERIOD_BITS-1:0] per_new;
        logic [PERIOD_BITS-1:0] eff_new;
        logic [DATA_W-1:0]      low_new;
        logic [DATA_W-1:0]      high_new;
        logic                   restart;

        state_next  = state_reg;
        biquad_next = biquad_reg;
        wet_next    = wet_reg;
        fb_next     = fb_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        period_next = period_reg;
        pos_next    = pos_reg;
        coef_next   = coef_reg;
        step_next   = step_reg;
        ch_next     = ch_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        xin_next    = xin_reg;
        mixl_next   = mixl_reg;
        mixr_next   = mixr_reg;
        x0_next     = x0_reg;
        tmp_next    = tmp_reg;
        s_next      = s_reg;
        resl_next   = resl_reg;
        resr_next   = resr_reg;
        posw_next   = posw_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        left_next   = left_reg;
        dcnt_next   = dcnt_reg;
        hv_next     = hv_reg;
        ovalid_next = ovalid_reg;
        outl_next   = outl_reg;
        outr_next   = outr_reg;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        eff     = (period_reg < PERIOD_BITS'(2)) ? PERIOD_BITS'(2) : period_reg;
        half    = eff >> 1;
        pos_e   = (pos_reg[ch_reg] >= eff) ? '0 : pos_reg[ch_reg];
        pos_inc = (posw_reg + 1'b1 >= eff) ? '0 : posw_reg + 1'b1;
        coef_c  = coef_reg[ch_reg];
        target  = (pos_e < half) ? high_reg : low_reg;

        div_r   = {rem_reg, quo_reg[DATA_W-1]};
        div_ge  = (div_r >= {1'b0, left_reg});
        quo_fin = {quo_reg[DATA_W-2:0], div_ge};

        hval = rvalid_reg ? ram_rdata : '0;
        if ($signed(hval) > CLAMP_HI)
        begin
            last = CLAMP_HI;
        end
        else if ($signed(hval) < CLAMP_LO)
        begin
            last = CLAMP_LO;
        end
        else
        begin
            last = hval;
        end

        wraw = mul_prod[2*DATA_W-1:DATA_W];
        wet  = {{8{wraw[DATA_W-1]}}, wraw[DATA_W-1:8]};
        tval = mul_prod[2*DATA_W-2:DATA_W-1];

        base      = ch_reg ? HIST_AW'(CH_WORDS) : '0;
        sec_addr  = base + HIST_AW'({k_reg, j_reg[1:0]});
        last_addr = base + HIST_AW'({SEC_W'(n_reg - 1'b1), 2'b10});
        ram_raddr = sec_addr;
        ram_waddr = sec_addr;

        psum = $signed({din.in_left[SAMPLE_W-1], din.in_left})
             + $signed({din.in_right[SAMPLE_W-1], din.in_right});

        if (ovalid_reg && dout.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    // floor of the pair average, scaled by 256
                    xin_next  = {{8{psum[SAMPLE_W]}}, psum[SAMPLE_W:1], 8'h00};
                    mixl_next = din.mix_left;
                    mixr_next = din.mix_right;
                    ch_next   = 1'b0;
                    if (biquad_reg < SEC_W'(2))
                    begin
                        n_next = SEC_W'(2);
                    end
                    else if (biquad_reg > SEC_W'(MAX_SECTIONS))
                    begin
                        n_next = SEC_W'(MAX_SECTIONS);
                    end
                    else
                    begin
                        n_next = biquad_reg;
                    end
                    state_next = ST_LFO_CHK;
                end
            end
            ST_LFO_CHK:
            begin
                posw_next = pos_e;
                if (pos_e == '0 || pos_e == half)
                begin
                    left_next = (pos_e < half) ? half - pos_e : eff - pos_e;
                    if ($signed(target) > $signed(coef_c))
                    begin
                        quo_next = target - coef_c;
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        quo_next = coef_c - target;
                        neg_next = 1'b1;
                    end
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FB_RD;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_next  = div_ge ? PERIOD_BITS'(div_r - {1'b0, left_reg})
                                   : div_r[PERIOD_BITS-1:0];
                quo_next  = quo_fin;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'(DATA_W - 1))
                begin
                    step_next[ch_reg] = neg_reg ? -quo_fin : quo_fin;
                    state_next        = ST_FB_RD;
                end
            end
            ST_FB_RD:
            begin
                ram_raddr  = last_addr;
                state_next = ST_FB_CLAMP;
            end
            ST_FB_CLAMP:
            begin
                // clamp the previous cascade output in place
                ram_we     = 1'b1;
                ram_waddr  = last_addr;
                ram_wdata  = last;
                hv_next[last_addr] = 1'b1;
                mul_start  = 1'b1;
                mul_a      = last;
                mul_b      = {{(MUL_B_W-FB_W){fb_reg[FB_W-1]}}, fb_reg};
                state_next = ST_FB_MUL;
            end
            ST_FB_MUL:
            begin
                if (mul_done)
                begin
                    x0_next    = xin_reg + mul_prod[DATA_W+15:16];
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_SEC_RD;
                end
            end
            ST_SEC_RD:
            begin
                // fetch x1, x2, y1, y2 of this section
                if (j_reg != '0)
                begin
                    s_next[2'(j_reg - 1'b1)] = hval;
                end
                j_next = j_reg + 1'b1;
                if (j_reg == 3'd4)
                begin
                    mul_start  = 1'b1;
                    mul_a      = x0_reg - hval;
                    mul_b      = {coef_c[DATA_W-1], coef_c};
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = tval + ((s_reg[2] - s_reg[0]) << 1);
                    mul_b      = {coef_c[DATA_W-1], coef_c};
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    tmp_next   = tval + s_reg[1];
                    j_next     = '0;
                    state_next = ST_SEC_WR;
                end
            end
            ST_SEC_WR:
            begin
                ram_we = 1'b1;
                hv_next[sec_addr] = 1'b1;
                unique case (j_reg[1:0])
                    2'd0:    ram_wdata = x0_reg;
                    2'd1:    ram_wdata = s_reg[0];
                    2'd2:    ram_wdata = tmp_reg;
                    default: ram_wdata = s_reg[2];
                endcase
                j_next = j_reg + 1'b1;
                if (j_reg == 3'd3)
                begin
                    x0_next = tmp_reg;
                    j_next  = '0;
                    k_next  = k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = tmp_reg;
                        mul_b      = {1'b0, wet_reg};
                        state_next = ST_WET;
                    end
                    else
                    begin
                        state_next = ST_SEC_RD;
                    end
                end
            end
            ST_WET:
            begin
                if (mul_done)
                begin
                    if (!ch_reg)
                    begin
                        resl_next = mixl_reg + wet;
                    end
                    else
                    begin
                        resr_next = mixr_reg + wet;
                    end
                    coef_next[ch_reg] = coef_c + step_reg[ch_reg];
                    pos_next[ch_reg]  = pos_inc;
                    if (!ch_reg)
                    begin
                        ch_next    = 1'b1;
                        state_next = ST_LFO_CHK;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!ovalid_reg || dout.ready)
                begin
                    outl_next   = resl_reg;
                    outr_next   = resr_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rvalid_next = hv_reg[ram_raddr];

        // configuration writes, to be made only while idle; the block itself does not enforce this
        restart  = 1'b0;
        per_new  = period_reg;
        low_new  = low_reg;
        high_new = high_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BIQUAD: biquad_next = cfg_data[SEC_W-1:0];
                REG_WET:    wet_next    = cfg_data;
                REG_FB:     fb_next     = cfg_data[FB_W-1:0];
                REG_LOW:
                begin
                    low_new = cfg_data;
                    restart = 1'b1;
                end
                REG_HIGH:
                begin
                    high_new = cfg_data;
                    restart  = 1'b1;
                end
                REG_PERIOD:
                begin
                    per_new = cfg_data[PERIOD_BITS-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        low_next    = low_new;
        high_next   = high_new;
        period_next = per_new;
        eff_new     = (per_new < PERIOD_BITS'(2)) ? PERIOD_BITS'(2) : per_new;
        if (restart)
        begin
            pos_next[0]  = '0;
            pos_next[1]  = eff_new >> 1;
            coef_next[0] = low_new;
            coef_next[1] = high_new;
            step_next[0] = '0;
            step_next[1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            biquad_reg <= RST_BIQUAD;
            wet_reg    <= RST_WET;
            fb_reg     <= RST_FB;
            low_reg    <= RST_LOW;
            high_reg   <= RST_HIGH;
            period_reg <= RST_PERIOD;
            pos_reg[0] <= '0;
            pos_reg[1] <= RST_POS_R;
            coef_reg[0] <= RST_LOW;
            coef_reg[1] <= RST_HIGH;
            step_reg[0] <= '0;
            step_reg[1] <= '0;
            ch_reg     <= 1'b0;
            k_reg      <= '0;
            j_reg      <= '0;
            n_reg      <= RST_BIQUAD;
            dcnt_reg   <= '0;
            hv_reg     <= '0;
            rvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            biquad_reg <= biquad_next;
            wet_reg    <= wet_next;
            fb_reg     <= fb_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            period_reg <= period_next;
            pos_reg    <= pos_next;
            coef_reg   <= coef_next;
            step_reg   <= step_next;
            ch_reg     <= ch_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            n_reg      <= n_next;
            dcnt_reg   <= dcnt_next;
            hv_reg     <= hv_next;
            rvalid_reg <= rvalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xin_reg  <= xin_next;
        mixl_reg <= mixl_next;
        mixr_reg <= mixr_next;
        x0_reg   <= x0_next;
        tmp_reg  <= tmp_next;
        s_reg    <= s_next;
        resl_reg <= resl_next;
        resr_reg <= resr_next;
        posw_reg <= posw_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        left_reg <= left_next;
        outl_reg <= outl_next;
        outr_reg <= outr_next;
    end

    assign din.ready      = (state_reg == ST_IDLE);
    assign dout.valid     = ovalid_reg;
    assign dout.out_left  = outl_reg;
    assign dout.out_right = outr_reg;

endmodule

>>> hw/rtl/sap_ram.sv
// generic single write port ram with registered read
// no dependencies
module sap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sap_serial_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on sap_pkg
module sap_serial_mul import sap_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DATA_W-1:0]    a,
    input  logic [MUL_B_W-1:0]   b,
    output logic                 done,
    output logic [MUL_P_W-1:0]   prod
);

    logic [DATA_W:0]        acc_reg, acc_next;
    logic [MUL_B_W-1:0]     mq_reg, mq_next;
    logic [DATA_W-1:0]      a_reg, a_next;
    logic [MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DATA_W+1:0]      sa;
    logic [DATA_W+1:0]      addend;
    logic [DATA_W+1:0]      sum;

    always_comb
    begin
        acc_next  = acc_reg;
        mq_next   = mq_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sa        = {{2{a_reg[DATA_W-1]}}, a_reg};
        // top multiplier bit carries negative weight
        if (!mq_reg[0])
        begin
            addend = '0;
        end
        else if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
        begin
            addend = -sa;
        end
        else
        begin
            addend = sa;
        end
        sum = {acc_reg[DATA_W], acc_reg} + addend;
        if (start)
        begin
            acc_next  = '0;
            mq_next   = b;
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[DATA_W+1:1];
            mq_next  = {sum[0], mq_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mq_reg  <= mq_next;
        a_reg   <= a_next;
    end

    assign done = done_reg;
    assign prod = {acc_reg, mq_reg};

endmodule

>>> hw/rtl/sap_checker.sv
// port checks of the stereo all-pass phaser, bound to the top level
// depends on assert_macros.svh and stereo_allpass_phaser
`include "assert_macros.svh"

module sap_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    `SAP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    `SAP_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second pair taken during work")

    `SAP_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without work")

    `SAP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind stereo_allpass_phaser sap_checker u_sap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready)
);

>>> dv/sap_mix_checker.sv
// checker for the stereo all-pass phaser: follows the register writes and the
// sample requests, predicts each mixed output pair and compares it
// depends on sap_pkg and the request interfaces in sap_if
module sap_mix_checker import sap_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    sap_in_if                    din,
    sap_out_if                   dout,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
    } mix_pair_t;

    logic [SEC_W-1:0]       sections;
    logic [DATA_W-1:0]      depth;
    logic [FB_W-1:0]        fb_gain;
    logic [DATA_W-1:0]      sweep_lo;
    logic [DATA_W-1:0]      sweep_hi;
    logic [PERIOD_BITS-1:0] period_reg;

    logic [DATA_W-1:0]      hist [2][CH_WORDS];
    logic [DATA_W-1:0]      lfo_pos [2];
    logic [DATA_W-1:0]      coef_now [2];
    logic [DATA_W-1:0]      coef_step [2];

    mix_pair_t expected_mix [$];

    function automatic logic [DATA_W-1:0] lfo_period_eff();
        return (period_reg < 2) ? 32'd2 : {8'd0, period_reg};
    endfunction

    function automatic void restart_sweep();
        lfo_pos[0]   = '0;
        lfo_pos[1]   = lfo_period_eff() >> 1;
        coef_now[0]  = sweep_lo;
        coef_now[1]  = sweep_hi;
        coef_step[0] = '0;
        coef_step[1] = '0;
    endfunction

    // low word of the signed product shifted right
    function automatic logic [DATA_W-1:0] prod_shr(logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b, int s);
        longint p;
        p = longint'($signed(a)) * longint'($signed(b));
        p = p >>> s;
        return p[31:0];
    endfunction

    function automatic logic [DATA_W-1:0] run_cascade(int ch, logic [DATA_W-1:0] x_in);
        logic [DATA_W-1:0] period, half, pos, coef, target, span, x0, t, y, fb;
        logic [63:0]       w;
        logic [DATA_W-1:0] wet;
        int                n;
        int                li;
        period = lfo_period_eff();
        half   = period >> 1;
        pos    = lfo_pos[ch];
        coef   = coef_now[ch];
        n      = sections;
        y      = '0;
        if (n < 2) n = 2;
        if (n > MAX_SECTIONS) n = MAX_SECTIONS;
        if (pos >= period) pos = '0;
        // new segment at each turn of the triangle
        if (pos == 0 || pos == half) begin
            if (pos < half) begin
                span = half - pos;
                target = sweep_hi;
            end
            else begin
                span = period - pos;
                target = sweep_lo;
            end
            if ($signed(target) > $signed(coef))
                coef_step[ch] = (target - coef) / span;
            else
                coef_step[ch] = 32'd0 - ((coef - target) / span);
        end
        li = (n - 1) * 4 + 2;
        if ($signed(hist[ch][li]) > CLAMP_HI) hist[ch][li] = CLAMP_HI;
        if ($signed(hist[ch][li]) < CLAMP_LO) hist[ch][li] = CLAMP_LO;
        fb = {{(DATA_W-FB_W){fb_gain[FB_W-1]}}, fb_gain};
        x0 = x_in + prod_shr(hist[ch][li], fb, 16);
        for (int k = 0; k < n; k++) begin
            t = x0 - hist[ch][k*4+3];
            t = prod_shr(t, coef, 31);
            t = t + ((hist[ch][k*4+2] - hist[ch][k*4]) << 1);
            t = prod_shr(t, coef, 31);
            t = t + hist[ch][k*4+1];
            hist[ch][k*4+1] = hist[ch][k*4];
            hist[ch][k*4+3] = hist[ch][k*4+2];
            hist[ch][k*4]   = x0;
            hist[ch][k*4+2] = t;
            x0 = t;
            y  = t;
        end
        w   = {{32{y[31]}}, y} * {32'd0, depth};
        wet = w[63:32];
        wet = {{8{wet[31]}}, wet[31:8]};
        coef_now[ch] = coef + coef_step[ch];
        pos = pos + 1;
        if (pos >= period) pos = '0;
        lfo_pos[ch] = pos;
        return wet;
    endfunction

    function automatic mix_pair_t predict_mix(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                                              logic [DATA_W-1:0] ml, logic [DATA_W-1:0] mr);
        logic signed [DATA_W-1:0] sum;
        logic [DATA_W-1:0]        x;
        mix_pair_t                res;
        sum = DATA_W'($signed(l)) + DATA_W'($signed(r));
        // floor halving, then up by 8
        x = (sum >>> 1) << 8;
        res.left  = ml + run_cascade(0, x);
        res.right = mr + run_cascade(1, x);
        return res;
    endfunction

    assign pending = expected_mix.size();

    always @(posedge clk or negedge rst_n) begin
        mix_pair_t exp_p;
        if (!rst_n) begin
            sections   = RST_BIQUAD;
            depth      = RST_WET;
            fb_gain    = RST_FB;
            sweep_lo   = RST_LOW;
            sweep_hi   = RST_HIGH;
            period_reg = RST_PERIOD;
            for (int c = 0; c < 2; c++)
                for (int i = 0; i < CH_WORDS; i++)
                    hist[c][i] = '0;
            restart_sweep();
            expected_mix.delete();
            errors = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_reg_t'(cfg_index))
                    REG_BIQUAD: sections = cfg_data[SEC_W-1:0];
                    REG_WET:    depth = cfg_data;
                    REG_FB:     fb_gain = cfg_data[FB_W-1:0];
                    REG_LOW:    begin sweep_lo = cfg_data; restart_sweep(); end
                    REG_HIGH:   begin sweep_hi = cfg_data; restart_sweep(); end
                    REG_PERIOD: begin period_reg = cfg_data[PERIOD_BITS-1:0]; restart_sweep(); end
                    default:    ;
                endcase
            end
            if (dout.valid && dout.ready) begin
                if (expected_mix.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output pair %h %h", dout.out_left, dout.out_right);
                end
                else begin
                    exp_p = expected_mix.pop_front();
                    if (dout.out_left !== exp_p.left || dout.out_right !== exp_p.right) begin
                        errors++;
                        if (errors <= 10)
                            $display("mix mismatch: expected %h %h got %h %h",
                                     exp_p.left, exp_p.right, dout.out_left, dout.out_right);
                    end
                end
            end
            if (din.valid && din.ready)
                expected_mix.push_back(predict_mix(din.in_left, din.in_right,
                                                   din.mix_left, din.mix_right));
        end
    end

endmodule

>>> dv/tb_top.sv
// top of the phaser regression: clock, reset, register phases, sample requests,
// output stalls and the verdict
// depends on sap_pkg, sap_if, the phaser rtl and sap_mix_checker
module tb_top import sap_pkg::*; ;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    int                   errors;
    int                   pending;
    int                   idle_cycles;
    bit                   no_stall;

    sap_in_if  din ();
    sap_out_if dout ();

    stereo_allpass_phaser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din.sink),
        .dout      (dout.source)
    );

    sap_mix_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din),
        .dout      (dout),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [DATA_W-1:0] sweep_value();
        case ($urandom_range(0, 5))
            0:       return 32'sd2126008811;
            1:       return -32'sd2126008811;
            default: return 32'(longint'($urandom_range(0, 32'd4252017622)) - 2126008811);
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_pair(logic [15:0] l, logic [15:0] r, logic [31:0] ml, logic [31:0] mr);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        @(negedge clk);
        cfg_write     <= 1'b0;
        din.valid     <= 1'b1;
        din.in_left   <= l;
        din.in_right  <= r;
        din.mix_left  <= ml;
        din.mix_right <= mr;
        @(posedge clk);
        while (!din.ready) @(posedge clk);
        @(negedge clk);
        din.valid <= 1'b0;
    endtask

    task automatic send_random_pair();
        logic [15:0] l, r;
        l = $urandom();
        r = $urandom();
        if ($urandom_range(0, 9) == 0) l = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        if ($urandom_range(0, 9) == 0) r = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        if ($urandom_range(0, 7) == 0) r = l;
        send_pair(l, r, $urandom(), $urandom());
    endtask

    task automatic random_setting(int ph);
        logic [DATA_W-1:0] lo, hi, t;
        lo = sweep_value();
        hi = sweep_value();
        // sweep mostly rising, some inverted
        if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi))
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        write_reg(REG_BIQUAD, (ph == 1) ? 32'd6 : (ph == 2) ? 32'd2 : $urandom());
        write_reg(REG_WET, (ph == 1) ? 32'hffff5a08 : (ph == 3) ? 32'd0 : $urandom());
        write_reg(REG_FB, (ph == 1) ? 32'd64880 : (ph == 2) ? -32'sd64880 :
                          (ph == 4) ? $urandom() :
                          32'(int'($urandom_range(0, 129760)) - 64880));
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        write_reg(REG_PERIOD, (ph == 1) ? 32'h00ffffff : (ph == 2) ? 32'd0 :
                              (ph == 3) ? 32'd1 : (ph == 4) ? $urandom() :
                              {8'($urandom_range(0, 255)), 24'd0}
                              | 32'($urandom_range(2, 60)));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // sink side: stalls at random, with stretches of no stall
    initial
    begin
        int g;
        dout.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (g > 0)
            begin
                dout.ready <= 1'b0;
                g--;
            end
            else
            begin
                dout.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) g = gap_len();
            end
        end
    end

    initial
    begin
        int pc;
        pc = 0;
        no_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            pc++;
            if (pc % 3000 == 0) no_stall = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((din.valid && din.ready) || (dout.valid && dout.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("stereo_allpass_phaser regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        din.valid     = 1'b0;
        din.in_left   = '0;
        din.in_right  = '0;
        din.mix_left  = '0;
        din.mix_right = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pairs under reset settings: extremes, equal and opposite inputs
        send_pair(16'h0000, 16'h0000, 32'h0, 32'h0);
        send_pair(16'h7fff, 16'h7fff, 32'h7fffffff, 32'h80000000);
        send_pair(16'h8000, 16'h8000, 32'h80000000, 32'h7fffffff);
        send_pair(16'h7fff, 16'h8000, 32'hffffffff, 32'h0);
        send_pair(16'hffff, 16'h0000, 32'h0, 32'hffffffff);
        send_pair(16'hfffd, 16'h0000, 32'h55555555, 32'haaaaaaaa);
        for (int i = 0; i < 10; i++)
            send_pair(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h7fff : 16'h8000,
                      $urandom(), $urandom());
        wait_idle();
        // short period, full feedback and deep cascade: clamp and turn handling
        write_reg(REG_PERIOD, 32'd2);
        write_reg(REG_FB, 32'd64880);
        write_reg(REG_BIQUAD, 32'd7);
        @(negedge clk);
        cfg_write <= 1'b0;
        for (int i = 0; i < 8; i++)
            send_pair(16'h7fff, 16'h7fff, 32'h0, 32'h0);
        wait_idle();

        for (int ph = 1; ph <= 10; ph++)
        begin
            random_setting(ph);
            for (int i = 0; i < 160; i++)
                send_random_pair();
            wait_idle();
        end

        if (errors == 0)
            $display("stereo_allpass_phaser regression: pass");
        else
            $display("stereo_allpass_phaser regression: fail");
        $finish;
    end

endmodule
